>>> rtl/version_string_compare_unit_macros.svh
// ----------------------------------------------------------------------------
// Version string compare unit: assertion macros
// Clocked property shorthands for the asserting file of the unit.
// ----------------------------------------------------------------------------
`ifndef VERSION_STRING_COMPARE_UNIT_MACROS_SVH
`define VERSION_STRING_COMPARE_UNIT_MACROS_SVH

// same-cycle implication, checked out of reset
`define VSC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define VSC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/vsc_pkg.sv
// ----------------------------------------------------------------------------
// Version string compare: shared package
// Widths, character codes, scan phases, tag recognizer and result codes.
// ----------------------------------------------------------------------------
package vsc_pkg;

    // numeric fields
    localparam int NUMBER_BITS = 31;
    localparam int ACC_BITS    = NUMBER_BITS + 4;
    localparam logic [NUMBER_BITS-1:0] NUMBER_MAX = '1;
    localparam logic [ACC_BITS-1:0]    DEC_BASE   = ACC_BITS'(10);

    // characters
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_Z  = 8'h5A;
    localparam logic [7:0] CASE_BIT = 8'h20;

    // result codes
    localparam logic [2:0] ERR_OK        = 3'd0;
    localparam logic [2:0] ERR_LEFT_BAD  = 3'd1;
    localparam logic [2:0] ERR_RIGHT_BAD = 3'd2;
    localparam logic [2:0] ERR_LEFT_TAG  = 3'd3;
    localparam logic [2:0] ERR_RIGHT_TAG = 3'd4;

    localparam logic signed [1:0] ORD_LESS    = -2'sd1;
    localparam logic signed [1:0] ORD_EQUAL   = 2'sd0;
    localparam logic signed [1:0] ORD_GREATER = 2'sd1;

    // scan phase of one string
    typedef enum logic [6:0] {
        PH_MAJOR    = 7'b0000001,
        PH_MINOR    = 7'b0000010,
        PH_PATCH    = 7'b0000100,
        PH_TAG      = 7'b0001000,
        PH_PNUM     = 7'b0010000,
        PH_PLUS     = 7'b0100000,
        PH_COMPLETE = 7'b1000000
    } t_phase;

    // tag recognizer states
    typedef enum logic [15:0] {
        TG_ROOT    = 16'h0001,
        TG_D       = 16'h0002,
        TG_DE      = 16'h0004,
        TG_DEV     = 16'h0008,
        TG_A       = 16'h0010,
        TG_AL      = 16'h0020,
        TG_ALP     = 16'h0040,
        TG_ALPH    = 16'h0080,
        TG_ALPHA   = 16'h0100,
        TG_B       = 16'h0200,
        TG_BE      = 16'h0400,
        TG_BET     = 16'h0800,
        TG_BETA    = 16'h1000,
        TG_R       = 16'h2000,
        TG_RC      = 16'h4000,
        TG_UNKNOWN = 16'h8000
    } t_tag;

    // finished string as seen by the comparator
    typedef struct packed {
        logic                   malformed;
        t_tag                   tag;
        logic [NUMBER_BITS-1:0] major;
        logic [NUMBER_BITS-1:0] minor;
        logic [NUMBER_BITS-1:0] patch;
        logic [NUMBER_BITS-1:0] pre;
    } t_scan_rec;

    // per-string scanner control from the top level
    typedef struct packed {
        logic upd;
        logic sel;
        logic no_char;
        logic last;
        logic force_end;
    } t_scan_ctl;

    typedef struct packed {
        logic       known;
        logic [1:0] rank;
    } t_rank;

    // advance the tag recognizer by one case-folded character
    function automatic t_tag f_tag_next(t_tag t, logic [7:0] c);
        logic [7:0] f;
        t_tag       n;
        f = c;
        if (c inside {[CH_UP_A:CH_UP_Z]}) begin
            f = c | CASE_BIT;
        end
        n = TG_UNKNOWN;
        case (t)
            TG_ROOT: begin
                if (f == "d") n = TG_D;
                if (f == "a") n = TG_A;
                if (f == "b") n = TG_B;
                if (f == "r") n = TG_R;
            end
            TG_D:    if (f == "e") n = TG_DE;
            TG_DE:   if (f == "v") n = TG_DEV;
            TG_A:    if (f == "l") n = TG_AL;
            TG_AL: begin
                if (f == "p") n = TG_ALP;
                if (f == "f") n = TG_ALPH;
            end
            TG_ALP:  if (f == "h") n = TG_ALPH;
            TG_ALPH: if (f == "a") n = TG_ALPHA;
            TG_B:    if (f == "e") n = TG_BE;
            TG_BE:   if (f == "t") n = TG_BET;
            TG_BET:  if (f == "a") n = TG_BETA;
            TG_R:    if (f == "c") n = TG_RC;
            default: n = TG_UNKNOWN;
        endcase
        return n;
    endfunction

    // rank of a finished tag: dev, alpha, beta, rc
    function automatic t_rank f_tag_rank(t_tag t);
        t_rank r;
        r = '{known: 1'b1, rank: 2'd0};
        case (t)
            TG_DEV:            r.rank = 2'd0;
            TG_A, TG_ALPHA:    r.rank = 2'd1;
            TG_B, TG_BETA:     r.rank = 2'd2;
            TG_RC:             r.rank = 2'd3;
            default:           r.known = 1'b0;
        endcase
        return r;
    endfunction

endpackage

>>> rtl/vsc_string_scan.sv
// ----------------------------------------------------------------------------
// Version string compare: single string scanner
// Holds the parse state of one string and applies one character per cycle while its update enable is set.
// ----------------------------------------------------------------------------
module vsc_string_scan
    import vsc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_scan_ctl  i_ctl,
    input  logic [7:0] i_char,
    output t_scan_rec  o_rec
);

    typedef struct packed {
        t_phase                 phase;
        logic [NUMBER_BITS-1:0] acc;
        logic                   has_digit;
        logic                   minus_seen;
        t_tag                   tag;
        logic [NUMBER_BITS-1:0] major;
        logic [NUMBER_BITS-1:0] minor;
        logic [NUMBER_BITS-1:0] patch;
        logic [NUMBER_BITS-1:0] pre;
        logic                   malformed;
    } t_scan_state;

    function automatic t_scan_state f_start();
        t_scan_state s;
        s            = '0;
        s.phase      = PH_MAJOR;
        s.tag        = TG_ROOT;
        return s;
    endfunction

    // close the field in progress, as at the end of the string
    function automatic t_scan_state f_close(t_scan_state s);
        t_scan_state n;
        n = s;
        case (s.phase)
            PH_MAJOR, PH_MINOR: n.malformed = 1'b1;
            PH_PATCH: begin
                if (!s.has_digit) n.malformed = 1'b1;
                n.patch = s.acc;
            end
            PH_TAG: begin
                if (s.tag == TG_ROOT) n.malformed = 1'b1;
            end
            PH_PNUM: begin
                if (!s.has_digit || (s.minus_seen && s.acc != '0)) n.malformed = 1'b1;
                n.pre = s.acc;
            end
            default: n = s;
        endcase
        n.acc        = '0;
        n.has_digit  = 1'b0;
        n.minus_seen = 1'b0;
        return n;
    endfunction

    // apply one character
    function automatic t_scan_state f_feed(t_scan_state s, logic [7:0] c);
        t_scan_state         n;
        logic                digit;
        logic [ACC_BITS-1:0] acc10;
        logic                ovf;
        n     = s;
        digit = (c >= CH_ZERO) && (c <= CH_NINE);
        acc10 = ACC_BITS'(s.acc) * DEC_BASE + ACC_BITS'(c[3:0]);
        ovf   = acc10 > ACC_BITS'(NUMBER_MAX);
        if (s.malformed || s.phase == PH_PLUS || s.phase == PH_COMPLETE) begin
            n = s;
        end else if (c == CH_PLUS) begin
            n       = f_close(s);
            n.phase = PH_PLUS;
        end else begin
            case (s.phase)
                PH_MAJOR, PH_MINOR, PH_PATCH: begin
                    if (digit) begin
                        if (ovf) n.malformed = 1'b1;
                        else     n.acc       = acc10[NUMBER_BITS-1:0];
                        n.has_digit = 1'b1;
                    end else if (c == CH_DOT && s.phase != PH_PATCH && s.has_digit) begin
                        if (s.phase == PH_MAJOR) begin
                            n.major = s.acc;
                            n.phase = PH_MINOR;
                        end else begin
                            n.minor = s.acc;
                            n.phase = PH_PATCH;
                        end
                        n.acc        = '0;
                        n.has_digit  = 1'b0;
                        n.minus_seen = 1'b0;
                    end else if (c == CH_DASH && s.phase == PH_PATCH) begin
                        n       = f_close(s);
                        n.phase = PH_TAG;
                    end else begin
                        n.malformed = 1'b1;
                    end
                end
                PH_TAG: begin
                    if (c == CH_DOT) n.phase = PH_PNUM;
                    else             n.tag   = f_tag_next(s.tag, c);
                end
                PH_PNUM: begin
                    if (digit) begin
                        if (ovf) n.malformed = 1'b1;
                        else     n.acc       = acc10[NUMBER_BITS-1:0];
                        n.has_digit = 1'b1;
                    end else if (c == CH_DASH && !s.has_digit && !s.minus_seen) begin
                        n.minus_seen = 1'b1;
                    end else begin
                        n.malformed = 1'b1;
                    end
                end
                default: n = s;
            endcase
        end
        return n;
    endfunction

    // end the string; an ended string stays as it is
    function automatic t_scan_state f_finish(t_scan_state s);
        t_scan_state n;
        n = s;
        if (s.phase != PH_COMPLETE) begin
            if (s.phase != PH_PLUS && !s.malformed) n = f_close(s);
            n.phase = PH_COMPLETE;
        end
        return n;
    endfunction

    t_scan_state r_state;
    t_scan_state n_state;
    t_scan_state w_cur;
    t_scan_state w_fed;

    // restart an ended string, take the character, end if asked
    always_comb begin
        w_cur = r_state;
        if (i_ctl.sel && r_state.phase == PH_COMPLETE) w_cur = f_start();
        w_fed = w_cur;
        if (i_ctl.sel && !i_ctl.no_char) w_fed = f_feed(w_cur, i_char);
        n_state = w_fed;
        if ((i_ctl.sel && i_ctl.last) || i_ctl.force_end) n_state = f_finish(w_fed);
    end

    // hold state between transactions
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= f_start();
        end else if (i_ctl.upd) begin
            r_state <= n_state;
        end
    end

    assign o_rec = '{malformed: n_state.malformed, tag: n_state.tag,
                     major: n_state.major, minor: n_state.minor,
                     patch: n_state.patch, pre: n_state.pre};

endmodule

>>> rtl/vsc_compare.sv
// ----------------------------------------------------------------------------
// Version string compare: record comparator
// Orders two finished strings or reports the first error that applies.
// ----------------------------------------------------------------------------
module vsc_compare
    import vsc_pkg::*;
(
    input  t_scan_rec         i_left,
    input  t_scan_rec         i_right,
    output logic signed [1:0] o_order,
    output logic [2:0]        o_error_code
);

    function automatic logic signed [1:0] f_cmp(logic [NUMBER_BITS-1:0] a,
                                                logic [NUMBER_BITS-1:0] b);
        logic signed [1:0] r;
        r = ORD_EQUAL;
        if (a < b) r = ORD_LESS;
        if (a > b) r = ORD_GREATER;
        return r;
    endfunction

    t_rank             w_lrank;
    t_rank             w_rrank;
    logic              w_lstable;
    logic              w_rstable;
    logic signed [1:0] w_order;
    logic [2:0]        w_err;

    assign w_lrank   = f_tag_rank(i_left.tag);
    assign w_rrank   = f_tag_rank(i_right.tag);
    assign w_lstable = i_left.tag == TG_ROOT;
    assign w_rstable = i_right.tag == TG_ROOT;

    // malformed strings first, then version fields, then stable over prerelease, then tag, then number
    always_comb begin
        w_order = ORD_EQUAL;
        w_err   = ERR_OK;
        if (i_left.malformed) begin
            w_err = ERR_LEFT_BAD;
        end else if (i_right.malformed) begin
            w_err = ERR_RIGHT_BAD;
        end else if (i_left.major != i_right.major) begin
            w_order = f_cmp(i_left.major, i_right.major);
        end else if (i_left.minor != i_right.minor) begin
            w_order = f_cmp(i_left.minor, i_right.minor);
        end else if (i_left.patch != i_right.patch) begin
            w_order = f_cmp(i_left.patch, i_right.patch);
        end else if (w_lstable && w_rstable) begin
            w_order = ORD_EQUAL;
        end else if (w_lstable) begin
            w_order = ORD_GREATER;
        end else if (w_rstable) begin
            w_order = ORD_LESS;
        end else if (!w_lrank.known) begin
            w_err = ERR_LEFT_TAG;
        end else if (!w_rrank.known) begin
            w_err = ERR_RIGHT_TAG;
        end else if (w_lrank.rank != w_rrank.rank) begin
            w_order = (w_lrank.rank < w_rrank.rank) ? ORD_LESS : ORD_GREATER;
        end else begin
            w_order = f_cmp(i_left.pre, i_right.pre);
        end
    end

    assign o_order      = w_order;
    assign o_error_code = w_err;

endmodule

>>> rtl/version_string_compare_unit.sv
// ----------------------------------------------------------------------------
// Version string compare unit: one character per cycle unless stalled, result on right end.
// The right last passes the input, compare and result registers before o_valid rises.
// Throughput: one transaction per cycle while o_stall is low.
// Reset: synchronous; both strings return to empty, pending results dropped.
// ----------------------------------------------------------------------------
`include "version_string_compare_unit_macros.svh"

module version_string_compare_unit
    import vsc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic              i_func,
    input  logic [7:0]        i_character,
    input  logic              i_no_character,
    input  logic              i_last,
    output logic              o_valid,
    input  logic              i_stall,
    output logic signed [1:0] o_order,
    output logic [2:0]        o_error_code
);

    logic              r_in_valid;
    logic              r_func;
    logic [7:0]        r_char;
    logic              r_no_char;
    logic              r_last;
    logic              r_cmp_valid;
    logic              n_cmp_valid;
    t_scan_rec         r_cmp_left;
    t_scan_rec         r_cmp_right;
    logic              r_out_valid;
    logic signed [1:0] r_order;
    logic [2:0]        r_err;

    logic              w_right_end;
    logic              w_out_free;
    logic              w_cmp_free;
    logic              w_proc;
    logic              w_in_free;
    t_scan_ctl         w_lctl;
    t_scan_ctl         w_rctl;
    t_scan_rec         w_lrec;
    t_scan_rec         w_rrec;
    logic signed [1:0] w_order;
    logic [2:0]        w_err;

    // flow control: only a right-string end needs room in the compare stage
    assign w_right_end = r_in_valid && r_func && r_last;
    assign w_out_free  = !r_out_valid || !i_stall;
    assign w_cmp_free  = !r_cmp_valid || w_out_free;
    assign w_proc      = r_in_valid && (!w_right_end || w_cmp_free);
    assign w_in_free   = !r_in_valid || w_proc;
    assign o_stall     = !w_in_free;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_free) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_free && i_valid) begin
            r_func    <= i_func;
            r_char    <= i_character;
            r_no_char <= i_no_character;
            r_last    <= i_last;
        end
    end

    // route the transaction; the left string also ends when the right one does
    assign w_lctl = '{upd: w_proc, sel: !r_func, no_char: r_no_char, last: r_last,
                      force_end: w_right_end};
    assign w_rctl = '{upd: w_proc, sel: r_func, no_char: r_no_char, last: r_last,
                      force_end: 1'b0};

    vsc_string_scan u_left (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_lctl),
        .i_char  (r_char),
        .o_rec   (w_lrec)
    );

    vsc_string_scan u_right (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_rctl),
        .i_char  (r_char),
        .o_rec   (w_rrec)
    );

    // snapshot both finished strings for the compare stage
    assign n_cmp_valid = (w_proc && w_right_end) || (r_cmp_valid && !w_out_free);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmp_valid <= 1'b0;
        end else begin
            r_cmp_valid <= n_cmp_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_proc && w_right_end) begin
            r_cmp_left  <= w_lrec;
            r_cmp_right <= w_rrec;
        end
    end

    vsc_compare u_compare (
        .i_left       (r_cmp_left),
        .i_right      (r_cmp_right),
        .o_order      (w_order),
        .o_error_code (w_err)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= r_cmp_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free && r_cmp_valid) begin
            r_order <= w_order;
            r_err   <= w_err;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_order      = r_order;
    assign o_error_code = r_err;

    // a pending compare is never dropped while the output is blocked
    `VSC_ASSERT_NEXT(a_cmp_held, r_cmp_valid && !w_out_free, r_cmp_valid, "compare lost")
    // a compare moving on always shows up at the output
    `VSC_ASSERT_NEXT(a_cmp_to_out, r_cmp_valid && w_out_free, o_valid, "result lost")
    // an error result carries no ordering
    `VSC_ASSERT_NOW(a_err_order, o_valid && o_error_code != ERR_OK, o_order == ORD_EQUAL, "order with error")

endmodule

>>> bench/version_order_checker.sv
// ----------------------------------------------------------------------------
// Version order checker
// Watches both channels of the version string compare unit, scans every
// accepted character into its own copy of the two version strings, predicts
// the comparison verdict at each right string end and checks the results.
// ----------------------------------------------------------------------------
module version_order_checker
    import vsc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_stall,
    input  logic              i_func,
    input  logic [7:0]        i_character,
    input  logic              i_no_character,
    input  logic              i_last,
    input  logic              i_out_valid,
    input  logic              i_out_stall,
    input  logic signed [1:0] i_order,
    input  logic [2:0]        i_error_code,
    output int                o_fail_count,
    output int                o_pending,
    output int                o_result_count
);

    localparam logic [63:0] NUM_LIMIT  = (64'd1 << NUMBER_BITS) - 64'd1;
    localparam int          SHOW_LIMIT = 10;

    // tag ranks, only their order matters
    localparam int RANK_UNKNOWN = -1;
    localparam int RANK_DEV     = 0;
    localparam int RANK_ALPHA   = 1;
    localparam int RANK_BETA    = 2;
    localparam int RANK_RC      = 3;

    typedef struct packed {
        logic signed [1:0] order;
        logic [2:0]        error_code;
    } t_verdict;

    t_verdict verdicts_due[$];

    // scan state, index 0 = left string, 1 = right string
    t_phase      scan_ph    [2];
    logic [63:0] num_acc    [2];
    logic        has_digit  [2];
    logic        minus_seen [2];
    logic [47:0] tag_word   [2];
    int          tag_len    [2];
    logic [63:0] major_v    [2];
    logic [63:0] minor_v    [2];
    logic [63:0] patch_v    [2];
    logic [63:0] pre_v      [2];
    logic        bad        [2];

    int fails;
    int results;
    int shown;

    function automatic void clear_number(int s);
        num_acc[s]    = '0;
        has_digit[s]  = 1'b0;
        minus_seen[s] = 1'b0;
    endfunction

    function automatic void open_string(int s);
        scan_ph[s]  = PH_MAJOR;
        clear_number(s);
        tag_word[s] = '0;
        tag_len[s]  = 0;
        major_v[s]  = '0;
        minor_v[s]  = '0;
        patch_v[s]  = '0;
        pre_v[s]    = '0;
        bad[s]      = 1'b0;
    endfunction

    // accumulate one decimal digit, flag overflow past the number limit
    function automatic void take_digit(int s, logic [7:0] d);
        if (num_acc[s] * 64'd10 + 64'(d) > NUM_LIMIT) begin
            bad[s] = 1'b1;
        end else begin
            num_acc[s] = num_acc[s] * 64'd10 + 64'(d);
        end
        has_digit[s] = 1'b1;
    endfunction

    // keep the first six folded tag bytes; longer tags count as unknown
    function automatic void add_tag_byte(int s, logic [7:0] c);
        logic [7:0] f;
        f = c;
        if (c >= CH_UP_A && c <= CH_UP_Z) begin
            f = c | CASE_BIT;
        end
        if (tag_len[s] < 6) begin
            tag_word[s] = {tag_word[s][39:0], f};
        end
        if (tag_len[s] < 7) begin
            tag_len[s]++;
        end
    endfunction

    function automatic int tag_rank(int s);
        int r;
        r = RANK_UNKNOWN;
        case (tag_len[s])
            1: begin
                if (tag_word[s][7:0] == "a") r = RANK_ALPHA;
                if (tag_word[s][7:0] == "b") r = RANK_BETA;
            end
            2: if (tag_word[s][15:0] == "rc") r = RANK_RC;
            3: if (tag_word[s][23:0] == "dev") r = RANK_DEV;
            4: begin
                if (tag_word[s][31:0] == "alfa") r = RANK_ALPHA;
                if (tag_word[s][31:0] == "beta") r = RANK_BETA;
            end
            5: if (tag_word[s][39:0] == "alpha") r = RANK_ALPHA;
            default: r = RANK_UNKNOWN;
        endcase
        return r;
    endfunction

    // end the field under scan, as at the end of the string
    function automatic void close_field(int s);
        case (scan_ph[s])
            PH_MAJOR, PH_MINOR: bad[s] = 1'b1;
            PH_PATCH: begin
                if (!has_digit[s]) bad[s] = 1'b1;
                patch_v[s] = num_acc[s];
            end
            PH_TAG: if (tag_len[s] == 0) bad[s] = 1'b1;
            PH_PNUM: begin
                if (!has_digit[s] || (minus_seen[s] && num_acc[s] != 0)) bad[s] = 1'b1;
                pre_v[s] = num_acc[s];
            end
            default: ;
        endcase
        clear_number(s);
    endfunction

    function automatic void scan_byte(int s, logic [7:0] c);
        logic digit;
        digit = (c >= CH_ZERO) && (c <= CH_NINE);
        if (bad[s] || scan_ph[s] == PH_PLUS || scan_ph[s] == PH_COMPLETE) return;
        // drop everything from the first plus on
        if (c == CH_PLUS) begin
            close_field(s);
            scan_ph[s] = PH_PLUS;
            return;
        end
        case (scan_ph[s])
            PH_MAJOR, PH_MINOR, PH_PATCH: begin
                if (digit) begin
                    take_digit(s, c - CH_ZERO);
                end else if (c == CH_DOT && scan_ph[s] != PH_PATCH && has_digit[s]) begin
                    if (scan_ph[s] == PH_MAJOR) major_v[s] = num_acc[s];
                    else                        minor_v[s] = num_acc[s];
                    clear_number(s);
                    scan_ph[s] = (scan_ph[s] == PH_MAJOR) ? PH_MINOR : PH_PATCH;
                end else if (c == CH_DASH && scan_ph[s] == PH_PATCH) begin
                    close_field(s);
                    scan_ph[s] = PH_TAG;
                end else begin
                    bad[s] = 1'b1;
                end
            end
            PH_TAG: begin
                if (c == CH_DOT) scan_ph[s] = PH_PNUM;
                else             add_tag_byte(s, c);
            end
            default: begin
                if (digit) begin
                    take_digit(s, c - CH_ZERO);
                end else if (c == CH_DASH && !has_digit[s] && !minus_seen[s]) begin
                    minus_seen[s] = 1'b1;
                end else begin
                    bad[s] = 1'b1;
                end
            end
        endcase
    endfunction

    function automatic void end_string(int s);
        if (scan_ph[s] == PH_COMPLETE) return;
        if (scan_ph[s] != PH_PLUS && !bad[s]) close_field(s);
        scan_ph[s] = PH_COMPLETE;
    endfunction

    function automatic logic signed [1:0] order_of(logic [63:0] a, logic [63:0] b);
        if (a < b) return ORD_LESS;
        if (a > b) return ORD_GREATER;
        return ORD_EQUAL;
    endfunction

    // compare left against right once both strings are closed
    function automatic t_verdict rank_versions();
        t_verdict v;
        int       lr;
        int       rr;
        logic     l_stable;
        logic     r_stable;
        v.order      = ORD_EQUAL;
        v.error_code = ERR_OK;
        if (bad[0]) begin
            v.error_code = ERR_LEFT_BAD;
        end else if (bad[1]) begin
            v.error_code = ERR_RIGHT_BAD;
        end else begin
            v.order = order_of(major_v[0], major_v[1]);
            if (v.order == ORD_EQUAL) v.order = order_of(minor_v[0], minor_v[1]);
            if (v.order == ORD_EQUAL) v.order = order_of(patch_v[0], patch_v[1]);
            if (v.order == ORD_EQUAL) begin
                l_stable = (tag_len[0] == 0);
                r_stable = (tag_len[1] == 0);
                if (l_stable && r_stable) begin
                    v.order = ORD_EQUAL;
                end else if (l_stable) begin
                    v.order = ORD_GREATER;
                end else if (r_stable) begin
                    v.order = ORD_LESS;
                end else begin
                    lr = tag_rank(0);
                    rr = tag_rank(1);
                    if (lr == RANK_UNKNOWN)      v.error_code = ERR_LEFT_TAG;
                    else if (rr == RANK_UNKNOWN) v.error_code = ERR_RIGHT_TAG;
                    else if (lr != rr)           v.order = (lr < rr) ? ORD_LESS : ORD_GREATER;
                    else                         v.order = order_of(pre_v[0], pre_v[1]);
                end
            end
        end
        if (v.error_code != ERR_OK) v.order = ORD_EQUAL;
        return v;
    endfunction

    // advance the prediction by one accepted input transaction
    function automatic void scan_transaction(logic f, logic [7:0] c, logic nc, logic l);
        int s;
        s = int'(f);
        if (scan_ph[s] == PH_COMPLETE) open_string(s);
        if (!nc) scan_byte(s, c);
        if (!l) return;
        end_string(s);
        if (s == 0) return;
        end_string(0);
        verdicts_due.push_back(rank_versions());
    endfunction

    // check results, then fold in the new input transaction
    always @(posedge i_clk) begin
        t_verdict want;
        if (!i_rst_n) begin
            open_string(0);
            open_string(1);
            verdicts_due.delete();
            fails   = 0;
            results = 0;
            shown   = 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                results++;
                if (verdicts_due.size() == 0) begin
                    fails++;
                    if (shown < SHOW_LIMIT) begin
                        shown++;
                        $display("mismatch: result %0d with nothing expected %s %0d %s %0d",
                                 results, "(order", $signed(i_order),
                                 "code", i_error_code);
                    end
                end else begin
                    want = verdicts_due.pop_front();
                    if (want.order !== i_order || want.error_code !== i_error_code) begin
                        fails++;
                        if (shown < SHOW_LIMIT) begin
                            shown++;
                            $display("mismatch: result %0d order exp %0d got %0d,",
                                     results, $signed(want.order), $signed(i_order));
                            $display("          code exp %0d got %0d",
                                     want.error_code, i_error_code);
                        end
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                scan_transaction(i_func, i_character, i_no_character, i_last);
            end
        end
        o_fail_count   <= fails;
        o_pending      <= verdicts_due.size();
        o_result_count <= results;
    end

endmodule

>>> bench/tb_version_string_compare_unit.sv
// ----------------------------------------------------------------------------
// Version string compare unit testbench
// Feeds directed and random version string pairs one character per
// transaction, with sender gaps, receiver stalls, a long receiver hold-off
// and drain pauses; the checker beside the block predicts every verdict.
// ----------------------------------------------------------------------------
module tb_version_string_compare_unit;
    import vsc_pkg::*;

    localparam int CLK_HALF     = 6;
    localparam int LIMIT_CYCLES = 400000;
    localparam int RANDOM_ITEMS = 500;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 8;

    typedef struct packed {
        logic       func;
        logic [7:0] ch;
        logic       no_char;
        logic       last;
    } t_feed_item;

    logic              i_clk          = 1'b0;
    logic              i_rst_n        = 1'b0;
    logic              i_valid        = 1'b0;
    logic              i_func         = 1'b0;
    logic [7:0]        i_character    = 8'h00;
    logic              i_no_character = 1'b0;
    logic              i_last         = 1'b0;
    logic              i_stall        = 1'b0;
    logic              o_stall;
    logic              o_valid;
    logic signed [1:0] o_order;
    logic [2:0]        o_error_code;

    int fail_count;
    int pending;
    int result_count;

    int cycles     = 0;
    int items_sent = 0;
    int burst_left = 0;
    int hold_offs  = 0;
    int pauses     = 0;
    bit gapless    = 1'b0;
    bit hold_req   = 1'b0;

    logic [7:0] txt[$];
    t_feed_item left_feed[$];
    t_feed_item right_feed[$];

    version_string_compare_unit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_func         (i_func),
        .i_character    (i_character),
        .i_no_character (i_no_character),
        .i_last         (i_last),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_order        (o_order),
        .o_error_code   (o_error_code)
    );

    version_order_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_valid),
        .i_in_stall     (o_stall),
        .i_func         (i_func),
        .i_character    (i_character),
        .i_no_character (i_no_character),
        .i_last         (i_last),
        .i_out_valid    (o_valid),
        .i_out_stall    (i_stall),
        .i_order        (o_order),
        .i_error_code   (o_error_code),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_result_count (result_count)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    always @(posedge i_clk) cycles <= cycles + 1;

    // end a hung run
    initial begin : watchdog
        while (cycles < LIMIT_CYCLES) @(posedge i_clk);
        $display("FAIL");
        $finish;
    end

    // receiver stall pattern, with a long hold-off on request
    int stall_mode = 0;
    int mode_left  = 0;
    int hold_left  = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES;
            hold_offs++;
            i_stall <= 1'b1;
        end else begin
            if (mode_left == 0) begin
                stall_mode = $urandom_range(0, 3);
                mode_left  = $urandom_range(10, 100);
            end
            mode_left--;
            case (stall_mode)
                0:       i_stall <= 1'b0;
                1:       i_stall <= ($urandom_range(0, 7) == 0);
                2:       i_stall <= $urandom_range(0, 1);
                default: i_stall <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    // offer one transaction and hold it until accepted, then maybe idle
    task automatic send_item(t_feed_item it);
        int gap;
        i_valid        <= 1'b1;
        i_func         <= it.func;
        i_character    <= it.ch;
        i_no_character <= it.no_char;
        i_last         <= it.last;
        do @(posedge i_clk); while (o_stall);
        items_sent++;
        if (!gapless) begin
            if (burst_left > 0) begin
                burst_left--;
            end else begin
                gap = $urandom_range(1, 8);
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
                burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 200)
                                                         : $urandom_range(0, 20);
            end
        end
    endtask

    task automatic put_str(string s);
        for (int i = 0; i < s.len(); i++) txt.push_back(s[i]);
    endtask

    // turn the text under construction into transactions of one string
    task automatic queue_text(logic side);
        t_feed_item it;
        logic       trailer;
        int         n;
        trailer = ($urandom_range(0, 11) == 0);
        n       = txt.size();
        if (n == 0) begin
            it = '{func: side, ch: 8'($urandom_range(0, 255)), no_char: 1'b1, last: 1'b1};
            if (side) right_feed.push_back(it);
            else      left_feed.push_back(it);
        end
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 15) == 0) begin
                it = '{func: side, ch: 8'($urandom_range(0, 255)), no_char: 1'b1, last: 1'b0};
                if (side) right_feed.push_back(it);
                else      left_feed.push_back(it);
            end
            it = '{func: side, ch: txt[i], no_char: 1'b0, last: (i == n - 1) && !trailer};
            if (side) right_feed.push_back(it);
            else      left_feed.push_back(it);
        end
        if (n != 0 && trailer) begin
            it = '{func: side, ch: 8'($urandom_range(0, 255)), no_char: 1'b1, last: 1'b1};
            if (side) right_feed.push_back(it);
            else      left_feed.push_back(it);
        end
        txt.delete();
    endtask

    // send the queued strings, left first or randomly interleaved
    task automatic play(logic mixed);
        logic pick_left;
        while (left_feed.size() != 0 || right_feed.size() != 0) begin
            pick_left = (right_feed.size() == 0) ||
                        (left_feed.size() != 0 && (!mixed || $urandom_range(0, 1) == 1));
            if (pick_left) send_item(left_feed.pop_front());
            else           send_item(right_feed.pop_front());
        end
    endtask

    function automatic logic [7:0] odd_byte();
        string letters;
        letters = "abcdefhlprtvABDELPRTV";
        case ($urandom_range(0, 9))
            0:       return CH_DOT;
            1:       return CH_DASH;
            2:       return CH_PLUS;
            3:       return 8'(CH_ZERO + $urandom_range(0, 9));
            4:       return letters[$urandom_range(0, letters.len() - 1)];
            5:       return 8'h00;
            6:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // mostly tiny values so that fields often tie, plus limit cases
    function automatic string num_text();
        int pick;
        pick = $urandom_range(0, 15);
        if (pick <= 9)  return $sformatf("%0d", $urandom_range(0, 2));
        if (pick == 10) return $sformatf("%0d", $urandom_range(3, 999));
        if (pick == 11) return $sformatf("%03d", $urandom_range(0, 2));
        if (pick == 12) return "2147483647";
        if (pick == 13) return "2147483648";
        if (pick == 14) return "0002147483647";
        if ($urandom_range(0, 1) == 1) return $sformatf("%0d", $urandom);
        return "99999999999";
    endfunction

    function automatic string pnum_text();
        case ($urandom_range(0, 9))
            0:       return "0";
            1:       return "1";
            2:       return "2";
            3:       return "-0";
            4:       return "-00";
            5:       return "-3";
            6:       return "-";
            7:       return "";
            8:       return "10";
            default: return num_text();
        endcase
    endfunction

    // known tags, near misses and junk, with random letter case
    task automatic put_tag();
        string w;
        case ($urandom_range(0, 15))
            0:       w = "dev";
            1:       w = "a";
            2:       w = "alfa";
            3:       w = "alpha";
            4:       w = "b";
            5:       w = "beta";
            6:       w = "rc";
            7:       w = "";
            8:       w = "al";
            9:       w = "alph";
            10:      w = "rcx";
            11:      w = "gamma";
            12:      w = "d";
            13:      w = "-";
            14:      w = "betaa";
            default: w = "";
        endcase
        for (int i = 0; i < w.len(); i++) begin
            if (w[i] >= "a" && w[i] <= "z" && $urandom_range(0, 1) == 1) begin
                w[i] = w[i] ^ CASE_BIT;
            end
        end
        put_str(w);
        if (w.len() == 0 && $urandom_range(0, 1) == 1) begin
            repeat ($urandom_range(1, 3)) txt.push_back(odd_byte());
        end
    endtask

    task automatic put_release(string maj, string mn, string pt);
        put_str({maj, ".", mn, ".", pt});
        if ($urandom_range(0, 9) < 6) begin
            txt.push_back(CH_DASH);
            put_tag();
            if ($urandom_range(0, 9) < 6) begin
                txt.push_back(CH_DOT);
                put_str(pnum_text());
            end
        end
        if ($urandom_range(0, 6) == 0) begin
            txt.push_back(CH_PLUS);
            repeat ($urandom_range(0, 4)) txt.push_back(odd_byte());
        end
    endtask

    // insert, drop or replace one byte of the text
    task automatic break_text();
        int op;
        op = (txt.size() == 0) ? 0 : $urandom_range(0, 2);
        case (op)
            0:       txt.insert($urandom_range(0, txt.size()), odd_byte());
            1:       txt.delete($urandom_range(0, txt.size() - 1));
            default: txt[$urandom_range(0, txt.size() - 1)] = odd_byte();
        endcase
    endtask

    task automatic put_noise();
        repeat ($urandom_range(0, 10)) txt.push_back(odd_byte());
    endtask

    // one random scenario: related pairs, single strings, noise, broken text
    task automatic random_round();
        string lmaj;
        string lmin;
        string lpat;
        int    kind;
        logic  mixed;
        kind  = $urandom_range(0, 19);
        mixed = ($urandom_range(0, 9) < 3);
        lmaj  = num_text();
        lmin  = num_text();
        lpat  = num_text();
        if (kind <= 13) begin
            put_release(lmaj, lmin, lpat);
            if ($urandom_range(0, 9) == 0) break_text();
            queue_text(1'b0);
            put_release(($urandom_range(0, 3) != 0) ? lmaj : num_text(),
                        ($urandom_range(0, 3) != 0) ? lmin : num_text(),
                        ($urandom_range(0, 3) != 0) ? lpat : num_text());
            if ($urandom_range(0, 9) == 0) break_text();
            queue_text(1'b1);
        end else if (kind <= 15) begin
            // right alone reuses the last left string
            put_release(lmaj, lmin, lpat);
            queue_text(1'b1);
        end else if (kind <= 17) begin
            put_noise();
            queue_text(1'b0);
            put_noise();
            queue_text(1'b1);
        end else if (kind == 18) begin
            // left alone gives no result
            put_release(lmaj, lmin, lpat);
            queue_text(1'b0);
        end else begin
            put_release(lmaj, lmin, lpat);
            break_text();
            queue_text(1'b0);
            put_release(lmaj, lmin, lpat);
            break_text();
            queue_text(1'b1);
        end
        play(mixed);
    endtask

    initial begin : stimulus
        int directed_items;
        int round;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        burst_left = 5;

        // right string with no left string ever sent
        queue_text(1'b1);
        play(1'b0);
        // both tagged and tied, left tag unknown (a zero byte)
        put_str("1.0.0-");
        txt.push_back(8'h00);
        queue_text(1'b0);
        put_str("1.0.0-A");
        queue_text(1'b1);
        play(1'b0);
        // left kept: tagged left against a stable right
        put_str("1.0.0");
        queue_text(1'b1);
        play(1'b0);
        // empty tag counts as stable, build text ignored
        put_str("0.0.0-.1");
        queue_text(1'b0);
        put_str("0.0.0+Z");
        queue_text(1'b1);
        play(1'b0);
        directed_items = items_sent;

        round = 0;
        while (items_sent - directed_items < RANDOM_ITEMS) begin
            round++;
            if (round == 3 || round == 60) begin
                // hold off the receiver while the sender keeps pushing
                hold_req = 1'b1;
                gapless  = 1'b1;
                repeat (16) begin
                    put_str($sformatf("0.0.%0d", $urandom_range(0, 2)));
                    queue_text(1'b0);
                    put_str($sformatf("0.0.%0d", $urandom_range(0, 2)));
                    queue_text(1'b1);
                    play(1'b0);
                end
                gapless = 1'b0;
            end else if (round == 6 || $urandom_range(0, 24) == 0) begin
                // pause the sender until every verdict is back
                i_valid <= 1'b0;
                do @(posedge i_clk); while (pending != 0);
                pauses++;
            end
            random_round();
        end

        // drain
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Summary: %0d input transactions, %0d verdicts checked, %0d cycles",
                 items_sent, result_count, cycles);
        $display("Summary: %0d receiver hold-offs, %0d drain pauses, %0d mismatches",
                 hold_offs, pauses, fail_count);
        if (fail_count == 0 && pending == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

>>> sim.f
+incdir+rtl
rtl/vsc_pkg.sv
rtl/vsc_string_scan.sv
rtl/vsc_compare.sv
rtl/version_string_compare_unit.sv
bench/version_order_checker.sv
bench/tb_version_string_compare_unit.sv
